### rtl/core/elfd_pkg.sv
// Package for the escaped length frame decoder.
// Holds the phase, result kind and error codes and the structs shared by
// the configuration block, the step logic and the top level.
package elfd_pkg;

   localparam int ByteWidth  = 8;
   localparam int LenWidth   = 16;
   localparam int IndexWidth = 3;

   localparam logic [IndexWidth-1:0] CSR_START_BYTE  = 3'd0;
   localparam logic [IndexWidth-1:0] CSR_END_BYTE    = 3'd1;
   localparam logic [IndexWidth-1:0] CSR_ESCAPE_BYTE = 3'd2;
   localparam logic [IndexWidth-1:0] CSR_START_CODE  = 3'd3;
   localparam logic [IndexWidth-1:0] CSR_ESCAPE_CODE = 3'd4;
   localparam logic [IndexWidth-1:0] CSR_END_CODE    = 3'd5;

   localparam logic [ByteWidth-1:0] RESET_START_BYTE  = 8'd126;
   localparam logic [ByteWidth-1:0] RESET_END_BYTE    = 8'd127;
   localparam logic [ByteWidth-1:0] RESET_ESCAPE_BYTE = 8'd125;
   localparam logic [ByteWidth-1:0] RESET_START_CODE  = 8'd94;
   localparam logic [ByteWidth-1:0] RESET_ESCAPE_CODE = 8'd93;
   localparam logic [ByteWidth-1:0] RESET_END_CODE    = 8'd95;

   localparam logic [ByteWidth-1:0] BAD_ESCAPE_VALUE = 8'h00;

   typedef enum logic [5:0] {
      PH_SEEK  = 6'b000001,
      PH_LENLO = 6'b000010,
      PH_LENHI = 6'b000100,
      PH_DATA  = 6'b001000,
      PH_EOF   = 6'b010000,
      PH_DONE  = 6'b100000
   } phase_type;

   typedef enum logic [1:0] {
      ERR_NONE  = 2'd0,
      ERR_ESC   = 2'd1,
      ERR_UNDER = 2'd2,
      ERR_OVER  = 2'd3
   } error_type;

   typedef enum logic [2:0] {
      K_CONSUMED = 3'd0,
      K_DATA     = 3'd1,
      K_RESTART  = 3'd2,
      K_DONE     = 3'd3,
      K_DONE_ERR = 3'd4,
      K_REFUSED  = 3'd5,
      K_CLEARED  = 3'd6
   } kind_type;

   typedef struct packed {
      logic [ByteWidth-1:0] start_byte;
      logic [ByteWidth-1:0] end_byte;
      logic [ByteWidth-1:0] escape_byte;
      logic [ByteWidth-1:0] start_escape_code;
      logic [ByteWidth-1:0] escape_escape_code;
      logic [ByteWidth-1:0] end_escape_code;
   } cfg_type;

   typedef struct packed {
      phase_type            phase;
      logic [LenWidth-1:0]  frame_length;
      logic [LenWidth-1:0]  data_count;
      logic                 escape_pending;
      error_type            first_error;
   } state_type;

   typedef struct packed {
      kind_type             result_kind;
      logic [ByteWidth-1:0] data_byte;
      error_type            error_code;
      logic                 byte_taken;
   } result_type;

endpackage

### rtl/core/elfd_csr.sv
// Configuration registers of the frame decoder.
// Uses elfd_pkg for the register indexes, reset values and cfg_type.
module elfd_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   input  logic                                csr_ready,
   input  logic [elfd_pkg::IndexWidth-1:0]     csr_index,
   input  logic [elfd_pkg::ByteWidth-1:0]      csr_data,
   output elfd_pkg::cfg_type                   cfg
);
   import elfd_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_START_BYTE:  cfg_in.start_byte         = csr_data;
            CSR_END_BYTE:    cfg_in.end_byte           = csr_data;
            CSR_ESCAPE_BYTE: cfg_in.escape_byte        = csr_data;
            CSR_START_CODE:  cfg_in.start_escape_code  = csr_data;
            CSR_ESCAPE_CODE: cfg_in.escape_escape_code = csr_data;
            CSR_END_CODE:    cfg_in.end_escape_code    = csr_data;
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_byte         <= RESET_START_BYTE;
         cfg_ff.end_byte           <= RESET_END_BYTE;
         cfg_ff.escape_byte        <= RESET_ESCAPE_BYTE;
         cfg_ff.start_escape_code  <= RESET_START_CODE;
         cfg_ff.escape_escape_code <= RESET_ESCAPE_CODE;
         cfg_ff.end_escape_code    <= RESET_END_CODE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### rtl/core/elfd_step.sv
// Next-state and result logic for one word of the frame decoder.
// Uses elfd_pkg for the phase, error and kind codes and the shared structs.
module elfd_step (
   input  elfd_pkg::cfg_type                 cfg,
   input  elfd_pkg::state_type               cur,
   input  logic                              action,
   input  logic [elfd_pkg::ByteWidth-1:0]    rx_byte,
   output elfd_pkg::state_type               nxt,
   output elfd_pkg::result_type              res
);
   import elfd_pkg::*;

   logic                 esc_ready;
   logic                 esc_bad;
   logic [ByteWidth-1:0] esc_val;
   logic                 is_start;
   logic                 is_end;
   logic                 restart;
   logic [LenWidth-1:0]  len_full;
   logic [LenWidth-1:0]  count_inc;

   assign is_start  = (rx_byte == cfg.start_byte);
   assign is_end    = (rx_byte == cfg.end_byte);
   assign len_full  = {esc_val, cur.frame_length[ByteWidth-1:0]};
   assign count_inc = cur.data_count + LenWidth'(1);

   always_comb begin
      esc_ready = 1'b1;
      esc_bad   = 1'b0;
      esc_val   = rx_byte;
      if (cur.escape_pending) begin
         if (rx_byte == cfg.start_escape_code) begin
            esc_val = cfg.start_byte;
         end else if (rx_byte == cfg.escape_escape_code) begin
            esc_val = cfg.escape_byte;
         end else if (rx_byte == cfg.end_escape_code) begin
            esc_val = cfg.end_byte;
         end else begin
            esc_val = BAD_ESCAPE_VALUE;
            esc_bad = 1'b1;
         end
      end else if (rx_byte == cfg.escape_byte) begin
         esc_ready = 1'b0;
      end
   end

   always_comb begin
      nxt             = cur;
      res.result_kind = K_CONSUMED;
      res.data_byte   = '0;
      res.byte_taken  = 1'b1;
      restart         = 1'b0;

      if (action) begin
         res.byte_taken = 1'b0;
         if (cur.phase == PH_LENLO || cur.phase == PH_LENHI ||
             cur.phase == PH_DATA || cur.phase == PH_EOF) begin
            res.result_kind = K_REFUSED;
         end else begin
            nxt.phase          = PH_SEEK;
            nxt.frame_length   = '0;
            nxt.data_count     = '0;
            nxt.escape_pending = 1'b0;
            nxt.first_error    = ERR_NONE;
            res.result_kind    = K_CLEARED;
         end
      end else if (cur.phase == PH_DONE) begin
         res.byte_taken  = 1'b0;
         res.result_kind = (cur.first_error == ERR_NONE) ? K_DONE : K_DONE_ERR;
      end else begin
         if (is_start) begin
            nxt.phase        = PH_SEEK;
            nxt.data_count   = '0;
            nxt.frame_length = '0;
            if (cur.data_count != '0) begin
               restart         = 1'b1;
               res.byte_taken  = 1'b0;
               res.result_kind = K_RESTART;
            end
         end
         if (!restart) begin
            if (is_end) begin
               nxt.phase = PH_EOF;
            end
            unique case (nxt.phase)
               PH_SEEK: begin
                  if (is_start) begin
                     nxt.phase = PH_LENLO;
                  end
               end
               PH_LENLO: begin
                  nxt.escape_pending = !esc_ready;
                  if (esc_bad && nxt.first_error == ERR_NONE) begin
                     nxt.first_error = ERR_ESC;
                  end
                  if (esc_ready) begin
                     nxt.frame_length = {{(LenWidth-ByteWidth){1'b0}}, esc_val};
                     nxt.phase        = PH_LENHI;
                  end
               end
               PH_LENHI: begin
                  nxt.escape_pending = !esc_ready;
                  if (esc_bad && nxt.first_error == ERR_NONE) begin
                     nxt.first_error = ERR_ESC;
                  end
                  if (esc_ready) begin
                     nxt.frame_length = len_full;
                     nxt.phase        = (len_full == '0) ? PH_EOF : PH_DATA;
                  end
               end
               PH_DATA: begin
                  nxt.escape_pending = !esc_ready;
                  if (esc_bad && nxt.first_error == ERR_NONE) begin
                     nxt.first_error = ERR_ESC;
                  end
                  if (esc_ready) begin
                     res.data_byte   = esc_val;
                     res.result_kind = K_DATA;
                     nxt.data_count  = count_inc;
                     if (count_inc >= cur.frame_length) begin
                        nxt.phase = PH_EOF;
                     end
                  end
               end
               PH_EOF: begin
                  if (is_end) begin
                     nxt.phase = PH_DONE;
                     if (nxt.data_count < nxt.frame_length &&
                         nxt.first_error == ERR_NONE) begin
                        nxt.first_error = ERR_UNDER;
                     end
                     res.result_kind = (nxt.first_error == ERR_NONE) ? K_DONE : K_DONE_ERR;
                  end else if (nxt.first_error == ERR_NONE) begin
                     nxt.first_error = ERR_OVER;
                  end
               end
               default: begin
                  nxt.phase = cur.phase;
               end
            endcase
         end
      end
      res.error_code = nxt.first_error;
   end

endmodule

### rtl/core/escaped_length_frame_decoder.sv
// Top level of the escaped length frame decoder.
// Instantiates elfd_csr and elfd_step; uses elfd_pkg for types and codes.
//
// Usage:
//   req_ channel: one word per item, req_action 0 carries a line byte in
//   req_rx_byte, req_action 1 asks to clear after a finished frame.
//   rsp_ channel: one result word per request word, in order: result kind,
//   unescaped data byte, sticky first error and whether the byte was taken.
//   A result with byte_taken 0 for a line byte means the same byte must be
//   sent again later (restart) or is refused until a clear (done phase).
//   csr_ channel: write index 0..5 to set start, end and escape bytes and
//   the three escape codes; csr_ready is always high, other indexes are
//   dropped. Write only while no request word is in flight.
// Path: the input register takes the request word, then the step logic
//   fills the result register, which drives the rsp_ channel.
// Throughput: one word per cycle while the result is taken, bounded by the state update.
// Reset: decoder seeks a start byte, length, count and error are cleared,
//   registers return to their defaults, both pipeline stages are empty.
// Stall: while rsp_ready is low the result holds, the input register keeps
//   one more word, then req_ready drops.
module escaped_length_frame_decoder (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_action,
   input  logic [elfd_pkg::ByteWidth-1:0]      req_rx_byte,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [2:0]                          rsp_result_kind,
   output logic [elfd_pkg::ByteWidth-1:0]      rsp_data_byte,
   output logic [1:0]                          rsp_error_code,
   output logic                                rsp_byte_taken,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [elfd_pkg::IndexWidth-1:0]     csr_index,
   input  logic [elfd_pkg::ByteWidth-1:0]      csr_data
);
   import elfd_pkg::*;

   cfg_type              cfg;
   state_type            state_ff;
   state_type            state_in;
   result_type           step_res;
   result_type           rsp_ff;
   logic                 rsp_valid_ff;
   logic                 in_valid_ff;
   logic                 in_action_ff;
   logic [ByteWidth-1:0] in_byte_ff;
   logic                 advance;

   assign csr_ready = 1'b1;

   elfd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   elfd_step u_step (
      .cfg     (cfg),
      .cur     (state_ff),
      .action  (in_action_ff),
      .rx_byte (in_byte_ff),
      .nxt     (state_in),
      .res     (step_res)
   );

   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff             <= 1'b0;
         rsp_valid_ff            <= 1'b0;
         state_ff.phase          <= PH_SEEK;
         state_ff.frame_length   <= '0;
         state_ff.data_count     <= '0;
         state_ff.escape_pending <= 1'b0;
         state_ff.first_error    <= ERR_NONE;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
            state_ff     <= state_in;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_action_ff <= req_action;
         in_byte_ff   <= req_rx_byte;
      end
      if (advance) begin
         rsp_ff <= step_res;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_kind = rsp_ff.result_kind;
   assign rsp_data_byte   = rsp_ff.data_byte;
   assign rsp_error_code  = rsp_ff.error_code;
   assign rsp_byte_taken  = rsp_ff.byte_taken;

endmodule
